// ===== sv/vtp_pkg.sv =====
// vtp_pkg: shared types and constants for the vertex transform block
// used by every module of the vertex transform; no dependencies
`timescale 1ns / 1ps
package vtp_pkg;
  localparam int FRAC_BITS = 16;
  localparam int NUM_REGS = 8;
  localparam int IDX_W = 3;
  // column sums: three 64-bit products plus a shifted coefficient
  localparam int SUM_W = 67;
  // dividend magnitude: sum magnitude shifted by FRAC_BITS
  localparam int NUM_W = SUM_W + FRAC_BITS;
  localparam int DEN_W = SUM_W;
  localparam int STAGES = NUM_W;

  typedef struct packed {
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic w_was_zero;
    logic saturated;
  } out_beat_t;

  // per-lane side info carried alongside the divider
  typedef struct packed {
    logic neg;
    logic wz;
    logic signed [SUM_W-1:0] pass;
  } lane_ctl_t;
endpackage

// ===== sv/vtp_mac.sv =====
// vtp_mac: one column dot product [x y z 1] * m[.][c], two pipeline stages
// depends on vtp_pkg
`timescale 1ns / 1ps
module vtp_mac (
  input  logic clk,
  input  logic en,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] z,
  input  logic signed [31:0] m0,
  input  logic signed [31:0] m1,
  input  logic signed [31:0] m2,
  input  logic signed [31:0] m3,
  output logic signed [vtp_pkg::SUM_W-1:0] sum
);
  logic signed [63:0] p0, p1, p2;
  logic signed [63:0] t3;

  // products registered before the add
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= x * m0;
      p1 <= y * m1;
      p2 <= z * m2;
      t3 <= 64'(m3) <<< vtp_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= vtp_pkg::SUM_W'(p0) + vtp_pkg::SUM_W'(p1) + vtp_pkg::SUM_W'(p2)
           + vtp_pkg::SUM_W'(t3);
    end
  end
endmodule

// ===== sv/vtp_div.sv =====
// vtp_div: pipelined restoring unsigned divider, one quotient bit per stage
// depends on vtp_pkg
`timescale 1ns / 1ps
module vtp_div (
  input  logic clk,
  input  logic en,
  input  logic [vtp_pkg::NUM_W-1:0] num,
  input  logic [vtp_pkg::DEN_W-1:0] den,
  input  vtp_pkg::lane_ctl_t ctl_in,
  output logic [vtp_pkg::NUM_W-1:0] quo,
  output vtp_pkg::lane_ctl_t ctl_out
);
  localparam int N = vtp_pkg::NUM_W;
  localparam int D = vtp_pkg::DEN_W;
  localparam int S = vtp_pkg::STAGES;

  logic [N-1:0] q [S+1];
  logic [N-1:0] n [S+1];
  logic [D:0]   r [S+1];
  logic [D-1:0] d [S+1];
  vtp_pkg::lane_ctl_t c [S+1];

  assign q[0] = '0;
  assign n[0] = num;
  assign r[0] = '0;
  assign d[0] = den;
  assign c[0] = ctl_in;

  for (genvar i = 0; i < S; i++) begin : g_stage
    logic [D:0] rs;
    logic [D+1:0] diff;
    assign rs = {r[i][D-1:0], n[i][N-1]};
    assign diff = {1'b0, rs} - {2'b0, d[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        n[i+1] <= {n[i][N-2:0], 1'b0};
        d[i+1] <= d[i];
        c[i+1] <= c[i];
        if (!diff[D+1]) begin
          r[i+1] <= diff[D:0];
          q[i+1] <= {q[i][N-2:0], 1'b1};
        end else begin
          r[i+1] <= rs;
          q[i+1] <= {q[i][N-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q[S];
  assign ctl_out = c[S];
endmodule

// ===== sv/vertex_transform_perspective.sv =====
// vertex_transform_perspective: top level, lanes of dot products and dividers
// depends on vtp_pkg, vtp_mac, vtp_div
`timescale 1ns / 1ps
// usage
//   in channel: in_valid / in_stall carry in_data (x, y, z Q16.16)
//   out channel: out_valid / out_stall carry out_data (x, y, z, flags)
//   cfg_we / cfg_idx / cfg_data write one 64-bit matrix register a cycle,
//   indexes 0 to 7; write only while the block is idle
// structure
//   four dot-product lanes (x, y, z, w) of two stages each, then three
//   divider lanes of one quotient bit per stage, then a merge stage that
//   negates, saturates and collects flags into the output register
// throughput
//   one vertex per cycle while no waiting result stalls the pipe; most of
//   the pipe's depth is in the bit-per-stage dividers
// stalls
//   the whole pipe advances together; in_stall is high exactly when the
//   output register holds a beat and out_stall is high, so a waiting
//   result freezes the pipe and intake in the same cycle
// reset
//   synchronous rst empties the pipe and loads the identity matrix
module vertex_transform_perspective (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  vtp_pkg::in_beat_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output vtp_pkg::out_beat_t out_data,
  input  logic cfg_we,
  input  logic [vtp_pkg::IDX_W-1:0] cfg_idx,
  input  logic [63:0] cfg_data
);
  localparam int SW = vtp_pkg::SUM_W;
  localparam int NW = vtp_pkg::NUM_W;
  localparam int DEPTH = 2 + vtp_pkg::STAGES;

  logic [63:0] regs [vtp_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= 64'd65536;
      regs[1] <= 64'd0;
      regs[2] <= 64'd65536 << 32;
      regs[3] <= 64'd0;
      regs[4] <= 64'd0;
      regs[5] <= 64'd65536;
      regs[6] <= 64'd0;
      regs[7] <= 64'd65536 << 32;
    end else if (cfg_we) begin
      regs[cfg_idx] <= cfg_data;
    end
  end

  // advance whenever the output register can take or is empty
  logic adv;
  logic [DEPTH-1:0] vld;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // coefficient m[r][c]: register 2r + c/2, half c%2
  logic signed [SW-1:0] sum [4];
  for (genvar c = 0; c < 4; c++) begin : g_mac
    logic [63:0] r0, r1, r2, r3;
    assign r0 = regs[0 + c/2];
    assign r1 = regs[2 + c/2];
    assign r2 = regs[4 + c/2];
    assign r3 = regs[6 + c/2];
    vtp_mac u_mac (
      .clk(clk), .en(adv),
      .x(in_data.x_in), .y(in_data.y_in), .z(in_data.z_in),
      .m0(c % 2 == 1 ? r0[63:32] : r0[31:0]),
      .m1(c % 2 == 1 ? r1[63:32] : r1[31:0]),
      .m2(c % 2 == 1 ? r2[63:32] : r2[31:0]),
      .m3(c % 2 == 1 ? r3[63:32] : r3[31:0]),
      .sum(sum[c])
    );
  end

  // combinational sign split ahead of the dividers
  logic signed [SW-1:0] w;
  logic wz;
  logic [SW-1:0] wmag;
  assign w = sum[3];
  assign wz = (w == '0);
  assign wmag = w[SW-1] ? SW'(-w) : SW'(w);

  logic [NW-1:0] quo [3];
  vtp_pkg::lane_ctl_t ctl [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [SW-1:0] cm;
    vtp_pkg::lane_ctl_t ci;
    assign cm = sum[i][SW-1] ? SW'(-sum[i]) : SW'(sum[i]);
    assign ci.neg = sum[i][SW-1] ^ w[SW-1];
    assign ci.wz = wz;
    assign ci.pass = sum[i] >>> vtp_pkg::FRAC_BITS;
    vtp_div u_div (
      .clk(clk), .en(adv),
      .num({cm, {vtp_pkg::FRAC_BITS{1'b0}}}),
      .den(wz ? SW'(1) : wmag),
      .ctl_in(ci),
      .quo(quo[i]), .ctl_out(ctl[i])
    );
  end

  // merge: sign, saturate, flags
  logic signed [31:0] res [3];
  logic sat_any;
  always_comb begin
    logic signed [NW:0] v;
    sat_any = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (ctl[i].wz) begin
        v = (NW+1)'(ctl[i].pass);
      end else if (ctl[i].neg) begin
        v = -$signed({1'b0, quo[i]});
      end else begin
        v = $signed({1'b0, quo[i]});
      end
      if (v > (NW+1)'(64'sh7FFFFFFF)) begin
        res[i] = 32'sh7FFFFFFF;
        sat_any = 1'b1;
      end else if (v < -(NW+1)'(64'sh80000000)) begin
        res[i] = 32'sh80000000;
        sat_any = 1'b1;
      end else begin
        res[i] = v[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.x_out <= res[0];
      out_data.y_out <= res[1];
      out_data.z_out <= res[2];
      out_data.w_was_zero <= ctl[0].wz;
      out_data.saturated <= sat_any;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("intake stalled with empty output register");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.x_out == 32'sh7FFFFFFF || out_data.x_out == 32'sh80000000 ||
       out_data.y_out == 32'sh7FFFFFFF || out_data.y_out == 32'sh80000000 ||
       out_data.z_out == 32'sh7FFFFFFF || out_data.z_out == 32'sh80000000))
    else $error("saturated flag without a clamped coordinate");
`endif
endmodule

// ===== tb/sv/tb_vertex_transform_perspective.sv =====
// tb_vertex_transform_perspective: self-checking bench for the vertex transform block
// depends on vtp_pkg and vertex_transform_perspective; predicts each result from a
// local copy of the matrix and checks it against every output beat
`timescale 1ns / 1ps
module tb_vertex_transform_perspective;

  localparam int DRAIN_CYCLES = 4 + vtp_pkg::NUM_W + 10;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  vtp_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  vtp_pkg::out_beat_t out_data;
  logic cfg_we;
  logic [vtp_pkg::IDX_W-1:0] cfg_idx;
  logic [63:0] cfg_data;

  vertex_transform_perspective u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // local copy of the matrix registers
  logic [63:0] matrix [vtp_pkg::NUM_REGS];

  vtp_pkg::in_beat_t vertex_q[$];
  vtp_pkg::out_beat_t projected_q[$];
  int errors = 0;
  int cycles = 0;
  int gap_max = 9;
  int in_gap = 0;
  int out_hold = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // signed coefficient at row r, column c
  function automatic logic signed [31:0] coef(int r, int c);
    logic [63:0] reg_val;
    reg_val = matrix[r * 2 + c / 2];
    return (c % 2) ? reg_val[63:32] : reg_val[31:0];
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v, ref bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // homogeneous transform plus divide by w, at full width
  function automatic vtp_pkg::out_beat_t project_vertex(vtp_pkg::in_beat_t v);
    logic signed [127:0] col [4];
    logic signed [127:0] a;
    logic signed [127:0] k;
    logic signed [127:0] res;
    logic signed [31:0] xyz [3];
    logic signed [31:0] outs [3];
    vtp_pkg::out_beat_t o;
    bit sat;
    xyz[0] = v.x_in;
    xyz[1] = v.y_in;
    xyz[2] = v.z_in;
    sat = 1'b0;
    for (int c = 0; c < 4; c++) begin
      k = 128'(coef(3, c));
      col[c] = k <<< vtp_pkg::FRAC_BITS;
      for (int r = 0; r < 3; r++) begin
        a = 128'(xyz[r]);
        k = 128'(coef(r, c));
        col[c] = col[c] + a * k;
      end
    end
    for (int i = 0; i < 3; i++) begin
      // zero w: pass through, shifted back to the output scale
      if (col[3] == 0) res = col[i] >>> vtp_pkg::FRAC_BITS;
      else res = (col[i] <<< vtp_pkg::FRAC_BITS) / col[3];
      outs[i] = clamp32(res, sat);
    end
    o.x_out = outs[0];
    o.y_out = outs[1];
    o.z_out = outs[2];
    o.w_was_zero = (col[3] == 0);
    o.saturated = sat;
    return o;
  endfunction

  // input side: one beat, then a random gap
  always @(negedge clk) begin
    logic nv;
    if (!rst) begin
      nv = in_valid;
      if (in_valid && in_taken) nv = 1'b0;
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (vertex_q.size() > 0) begin
          in_data <= vertex_q.pop_front();
          nv = 1'b1;
          in_gap = $urandom_range(0, gap_max);
        end
      end
      in_valid <= nv;
    end
    in_taken = 1'b0;
  end

  // output side: random stall after each beat
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) out_hold = $urandom_range(0, gap_max);
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
    out_taken = 1'b0;
  end

  // monitor: predict on intake, compare on output
  always @(posedge clk) begin
    vtp_pkg::out_beat_t exp_beat;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else if (!rst) begin
      if (in_valid && !in_stall) begin
        projected_q.push_back(project_vertex(in_data));
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        if (projected_q.size() == 0) begin
          $error("output beat with nothing expected");
          errors++;
        end else begin
          exp_beat = projected_q.pop_front();
          if (out_data.x_out !== exp_beat.x_out) begin
            $error("x_out expected %0d got %0d", exp_beat.x_out, out_data.x_out);
            errors++;
          end
          if (out_data.y_out !== exp_beat.y_out) begin
            $error("y_out expected %0d got %0d", exp_beat.y_out, out_data.y_out);
            errors++;
          end
          if (out_data.z_out !== exp_beat.z_out) begin
            $error("z_out expected %0d got %0d", exp_beat.z_out, out_data.z_out);
            errors++;
          end
          if (out_data.w_was_zero !== exp_beat.w_was_zero) begin
            $error("w_was_zero expected %0b got %0b", exp_beat.w_was_zero,
                   out_data.w_was_zero);
            errors++;
          end
          if (out_data.saturated !== exp_beat.saturated) begin
            $error("saturated expected %0b got %0b", exp_beat.saturated,
                   out_data.saturated);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_matrix(logic [63:0] vals [vtp_pkg::NUM_REGS]);
    for (int i = 0; i < vtp_pkg::NUM_REGS; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_idx <= vtp_pkg::IDX_W'(i);
      cfg_data <= vals[i];
      matrix[i] = vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (vertex_q.size() > 0 || in_valid || projected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 8 << vtp_pkg::FRAC_BITS) - (4 << vtp_pkg::FRAC_BITS);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          default: return $urandom_range(0, 3) - 1;
        endcase
      end
    endcase
  endfunction

  function automatic vtp_pkg::in_beat_t pick_vertex();
    vtp_pkg::in_beat_t v;
    int mode;
    mode = $urandom_range(0, 9);
    mode = (mode < 3) ? 0 : (mode < 9) ? 1 : 2;
    v.x_in = pick_coord(mode);
    v.y_in = pick_coord(mode);
    v.z_in = pick_coord(mode);
    return v;
  endfunction

  // small coefficient, with a fraction part
  function automatic logic [31:0] pick_coef();
    return $urandom_range(0, 6 << vtp_pkg::FRAC_BITS) - (3 << vtp_pkg::FRAC_BITS);
  endfunction

  task automatic run_vertices(int count);
    for (int i = 0; i < count; i++) vertex_q.push_back(pick_vertex());
  endtask

  initial begin
    logic [63:0] vals [vtp_pkg::NUM_REGS];
    vtp_pkg::in_beat_t v;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_data = '0;
    // identity after reset
    matrix[0] = 64'd65536;
    matrix[1] = 64'd0;
    matrix[2] = 64'd1 << 48;
    matrix[3] = 64'd0;
    matrix[4] = 64'd0;
    matrix[5] = 64'd65536;
    matrix[6] = 64'd0;
    matrix[7] = 64'd1 << 48;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: field extremes through the identity
    v = '{32'h7fffffff, 32'h80000000, 32'h0};
    vertex_q.push_back(v);
    v = '{32'h80000000, 32'h7fffffff, 32'hffffffff};
    vertex_q.push_back(v);
    v = '{32'h0, 32'h0, 32'h0};
    vertex_q.push_back(v);
    v = '{32'hffffffff, 32'h1, 32'h00010000};
    vertex_q.push_back(v);
    wait_idle();

    // zero w with translation: undivided pass-through with floor shift
    vals = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
             {32'hfffe8000, 32'h00018001}, {32'h0, 32'h7fffffff}};
    write_matrix(vals);
    v = '{32'h1, 32'h2, 32'h3};
    vertex_q.push_back(v);
    v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
    vertex_q.push_back(v);
    wait_idle();

    // extreme matrices: all ones, all minimum, all maximum
    vals = '{default: 64'hffffffffffffffff};
    write_matrix(vals);
    for (int i = 0; i < 4; i++) vertex_q.push_back(pick_vertex());
    v = '{32'h1, 32'h0, 32'h0};
    vertex_q.push_back(v);
    wait_idle();
    vals = '{default: 64'h8000000080000000};
    write_matrix(vals);
    v = '{32'h80000000, 32'h80000000, 32'h80000000};
    vertex_q.push_back(v);
    run_vertices(4);
    wait_idle();
    vals = '{default: 64'h7fffffff7fffffff};
    write_matrix(vals);
    v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    vertex_q.push_back(v);
    run_vertices(4);
    wait_idle();

    // random phases: perspective-like small matrices, some fully random,
    // every third phase without idling
    for (int p = 0; p < 8; p++) begin
      gap_max = (p % 3 == 2) ? 0 : 9;
      for (int i = 0; i < vtp_pkg::NUM_REGS; i++) begin
        if (p % 4 == 3) vals[i] = {$urandom(), $urandom()};
        else vals[i] = {pick_coef(), pick_coef()};
      end
      // in phase 5, force w to vanish
      if (p == 5) begin
        vals[1][63:32] = 32'h0;
        vals[3][63:32] = 32'h0;
        vals[5][63:32] = 32'h0;
        vals[7][63:32] = 32'h0;
      end
      write_matrix(vals);
      run_vertices(100);
      wait_idle();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
